[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros sample on clk and are off while arst_n is low.
`define BSTP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define BSTP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/bstp_pkg.sv]
package bstp_pkg;

	// header layout
	localparam int HEADER_LEN = 54;
	localparam logic [5:0] HDR_LAST       = 6'(HEADER_LEN - 1);
	localparam logic [5:0] HDR_OFFSET_LO  = 6'd10;
	localparam logic [5:0] HDR_OFFSET_HI  = 6'd11;
	localparam logic [5:0] HDR_WIDTH_LO   = 6'd18;
	localparam logic [5:0] HDR_WIDTH_HI   = 6'd19;
	localparam logic [5:0] HDR_HEIGHT_LO  = 6'd22;
	localparam logic [5:0] HDR_HEIGHT_HI  = 6'd23;
	localparam logic [5:0] HDR_DEPTH      = 6'd28;

	localparam logic [7:0] DEPTH_1  = 8'd1;
	localparam logic [7:0] DEPTH_4  = 8'd4;
	localparam logic [7:0] DEPTH_24 = 8'd24;

	localparam logic [1:0] COLOR_WHITE = 2'd0;
	localparam logic [1:0] COLOR_BLACK = 2'd1;
	localparam logic [1:0] COLOR_RED   = 2'd2;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	// configuration registers
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_RED_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DARK_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_NIBBLE_RED_MIN = 2'd2;
	localparam logic [7:0] RST_RED_THRESHOLD  = 8'd200;
	localparam logic [7:0] RST_DARK_THRESHOLD = 8'd100;
	localparam logic [3:0] RST_NIBBLE_RED_MIN = 4'hC;

	// job queue between front and back; depth must be a power of two
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} byte_word_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] pixel_x;
		logic [15:0] pixel_y;
		logic [1:0]  color;
		logic        end_of_image;
		logic        last_in_run;
	} pix_word_t;

	// one input byte worth of results: cnt pixels starting at column x
	typedef struct packed {
		logic            err;
		logic [3:0]      cnt;
		logic [7:0][1:0] colors;
		logic [15:0]     x;
		logic [15:0]     y;
		logic            eoi;
	} job_t;

endpackage

[hw/rtl/bstp_stream_if.sv]
interface bstp_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/bstp_front.sv]
`include "assert_macros.svh"

module bstp_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bstp_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [7:0]                       cfg_wdata,
	bstp_stream_if.sink                      byte_in,
	input  logic                             q_full,
	output logic                             push,
	output bstp_pkg::job_t                   push_job
);
	import bstp_pkg::*;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_SKIP   = 4'b0010,
		PH_DATA   = 4'b0100,
		PH_IDLE   = 4'b1000
	} phase_t;

	phase_t      phase_q;
	logic [5:0]  hdr_cnt_q;
	logic [15:0] width_q, height_q, offset_q, file_row_q;
	logic [7:0]  depth_q, blue_q, green_q;
	logic [17:0] row_size_q, byte_pos_q;
	logic [1:0]  ch_q;
	logic [16:0] px_q;
	logic [7:0]  red_th_q, dark_th_q;
	logic [3:0]  nib_min_q;

	logic        accept, restart;
	logic [7:0]  b;
	logic        is1, is4, is24, bad_depth;
	logic [20:0] bits, bits_rnd;
	logic [17:0] row_size_calc;
	logic [20:0] base;
	logic [3:0]  kstep, n_pix;
	logic        in_range, last_row, eoi;
	logic [15:0] rem, disp_y;
	logic [7:0][1:0] colors;
	logic        gb_dark;
	logic [1:0]  rgb_color;
	logic [18:0] pos_next;
	logic        row_end;

	function automatic logic [1:0] nib_color(input logic [3:0] v, input logic [3:0] vmin);
		logic [1:0] c;
		c = COLOR_WHITE;
		if (v == 4'd0) c = COLOR_BLACK;
		else if (v >= vmin) c = COLOR_RED;
		return c;
	endfunction

	assign byte_in.ready = !q_full;
	assign accept  = byte_in.valid && byte_in.ready;
	assign restart = byte_in.data.start_of_file;
	assign b       = byte_in.data.data_byte;

	assign is1       = depth_q == DEPTH_1;
	assign is4       = depth_q == DEPTH_4;
	assign is24      = depth_q == DEPTH_24;
	assign bad_depth = !(is1 || is4 || is24);

	// padded row length in bytes
	always_comb begin
		bits = 21'(width_q);
		if (is4) bits = {width_q, 2'b00} + 21'd0;
		else if (is24) bits = {1'b0, width_q, 4'b0000} + {2'b00, width_q, 3'b000};
		bits_rnd = bits + 21'd31;
		row_size_calc = {bits_rnd[20:5], 2'b00};
	end

	// pixel span covered by this byte
	always_comb begin
		base  = 21'(px_q);
		kstep = 4'd1;
		if (is1) begin
			base  = {byte_pos_q, 3'b000};
			kstep = 4'd8;
		end else if (is4) begin
			base  = 21'({byte_pos_q, 1'b0});
			kstep = 4'd2;
		end
		in_range = base < 21'(width_q);
		rem      = width_q - base[15:0];
		n_pix    = (rem >= 16'(kstep)) ? kstep : rem[3:0];
		last_row = (17'(file_row_q) + 17'd1) == 17'(height_q);
		eoi      = in_range && (rem <= 16'(kstep)) && last_row;
		disp_y   = height_q - file_row_q - 16'd1;
	end

	always_comb begin
		gb_dark = (green_q < dark_th_q) && (blue_q < dark_th_q);
		rgb_color = COLOR_WHITE;
		if (b > red_th_q && gb_dark) rgb_color = COLOR_RED;
		else if (b < dark_th_q && gb_dark) rgb_color = COLOR_BLACK;
		colors = '0;
		if (is1) begin
			for (int i = 0; i < 8; i++) begin
				colors[i] = b[7-i] ? COLOR_WHITE : COLOR_BLACK;
			end
		end else if (is4) begin
			colors[0] = nib_color(b[7:4], nib_min_q);
			colors[1] = nib_color(b[3:0], nib_min_q);
		end else begin
			colors[0] = rgb_color;
		end
	end

	assign pos_next = 19'(byte_pos_q) + 19'd1;
	assign row_end  = pos_next >= 19'(row_size_q);

	always_comb begin
		push     = 1'b0;
		push_job = '0;
		if (accept && !restart) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hdr_cnt_q == HDR_LAST && bad_depth) begin
						push         = 1'b1;
						push_job.err = KIND_ERROR;
						push_job.cnt = 4'd1;
					end
				end
				PH_DATA: begin
					if (in_range && (!is24 || ch_q == 2'd2)) begin
						push            = 1'b1;
						push_job.err    = KIND_PIXEL;
						push_job.cnt    = n_pix;
						push_job.colors = colors;
						push_job.x      = base[15:0];
						push_job.y      = disp_y;
						push_job.eoi    = eoi;
					end
				end
				PH_SKIP, PH_IDLE: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_th_q  <= RST_RED_THRESHOLD;
			dark_th_q <= RST_DARK_THRESHOLD;
			nib_min_q <= RST_NIBBLE_RED_MIN;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_RED_THRESHOLD:  red_th_q  <= cfg_wdata;
				REG_DARK_THRESHOLD: dark_th_q <= cfg_wdata;
				REG_NIBBLE_RED_MIN: nib_min_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_cnt_q  <= '0;
			width_q    <= '0;
			height_q   <= '0;
			depth_q    <= '0;
			offset_q   <= '0;
			row_size_q <= '0;
			byte_pos_q <= '0;
			file_row_q <= '0;
			blue_q     <= '0;
			green_q    <= '0;
			ch_q       <= '0;
			px_q       <= '0;
		end else if (accept) begin
			if (restart) begin
				// this byte is header byte zero, which holds no captured field
				phase_q   <= PH_HEADER;
				hdr_cnt_q <= 6'd1;
				width_q   <= '0;
				height_q  <= '0;
				depth_q   <= '0;
				offset_q  <= '0;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						case (hdr_cnt_q)
							HDR_OFFSET_LO: offset_q[7:0]  <= b;
							HDR_OFFSET_HI: offset_q[15:8] <= b;
							HDR_WIDTH_LO:  width_q[7:0]   <= b;
							HDR_WIDTH_HI:  width_q[15:8]  <= b;
							HDR_HEIGHT_LO: height_q[7:0]  <= b;
							HDR_HEIGHT_HI: height_q[15:8] <= b;
							HDR_DEPTH:     depth_q        <= b;
							default: ;
						endcase
						if (hdr_cnt_q == HDR_LAST) begin
							byte_pos_q <= '0;
							file_row_q <= '0;
							ch_q       <= '0;
							px_q       <= '0;
							if (bad_depth) begin
								row_size_q <= '0;
								phase_q    <= PH_IDLE;
							end else begin
								row_size_q <= row_size_calc;
								if (width_q == '0 || height_q == '0) begin
									phase_q <= PH_IDLE;
								end else if (offset_q > 16'(HEADER_LEN)) begin
									byte_pos_q <= 18'(offset_q - 16'(HEADER_LEN));
									phase_q    <= PH_SKIP;
								end else begin
									phase_q <= PH_DATA;
								end
							end
						end else begin
							hdr_cnt_q <= hdr_cnt_q + 6'd1;
						end
					end
					PH_SKIP: begin
						byte_pos_q <= byte_pos_q - 18'd1;
						if (byte_pos_q == 18'd1) phase_q <= PH_DATA;
					end
					PH_DATA: begin
						if (is24) begin
							if (ch_q == 2'd0) blue_q <= b;
							if (ch_q == 2'd1) green_q <= b;
						end
						if (row_end) begin
							byte_pos_q <= '0;
							ch_q       <= '0;
							px_q       <= '0;
							file_row_q <= file_row_q + 16'd1;
							if (last_row) phase_q <= PH_IDLE;
						end else begin
							byte_pos_q <= pos_next[17:0];
							ch_q       <= (ch_q == 2'd2) ? 2'd0 : ch_q + 2'd1;
							px_q       <= (ch_q == 2'd2) ? px_q + 17'd1 : px_q;
						end
					end
					PH_IDLE: ;
					default: phase_q <= PH_IDLE;
				endcase
			end
		end
	end

	`BSTP_ASSERT_IMP(a_data_dims, phase_q == PH_DATA,
		width_q != '0 && height_q != '0 && row_size_q != '0,
		"data phase entered with empty image or zero row size")
	`BSTP_ASSERT_IMP(a_pos_in_row, phase_q == PH_DATA, byte_pos_q < row_size_q,
		"byte position ran past the padded row")
	`BSTP_ASSERT_IMP(a_skip_nonzero, phase_q == PH_SKIP, byte_pos_q != '0,
		"skip phase with nothing left to skip")

endmodule

[hw/rtl/bstp_queue.sv]
module bstp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bstp_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output bstp_pkg::job_t head
);
	import bstp_pkg::*;

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	job_t                mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] cnt_q;

	assign full       = cnt_q == CNT_BITS'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			if (push && !pop) cnt_q <= cnt_q + CNT_BITS'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_BITS'(1);
		end
	end

endmodule

[hw/rtl/bstp_back.sv]
`include "assert_macros.svh"

module bstp_back #(
	parameter int COORD_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  bstp_pkg::job_t head,
	output logic           pop,
	bstp_stream_if.source  pix_out
);
	import bstp_pkg::*;

	logic                  out_v_q;
	logic [2:0]            idx_q;
	logic                  kind_q, eoi_q, last_q;
	logic [COORD_BITS-1:0] x_q, y_q;
	logic [1:0]            color_q;

	logic                  load, last;
	logic [COORD_BITS-1:0] x_next;

	assign load   = !out_v_q || pix_out.ready;
	assign last   = (4'(idx_q) + 4'd1) == head.cnt;
	assign pop    = load && head_valid && last;
	assign x_next = head.x[COORD_BITS-1:0] + COORD_BITS'(idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			out_v_q <= head_valid;
			if (head_valid) idx_q <= last ? 3'd0 : idx_q + 3'd1;
		end
	end

	// hold the word while the sink stalls
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			kind_q  <= head.err;
			x_q     <= x_next;
			y_q     <= head.y[COORD_BITS-1:0];
			color_q <= head.colors[idx_q];
			eoi_q   <= head.eoi && last;
			last_q  <= last;
		end
	end

	assign pix_out.valid             = out_v_q;
	assign pix_out.data.kind         = kind_q;
	assign pix_out.data.pixel_x      = 16'(x_q);
	assign pix_out.data.pixel_y      = 16'(y_q);
	assign pix_out.data.color        = color_q;
	assign pix_out.data.end_of_image = eoi_q;
	assign pix_out.data.last_in_run  = last_q;

	`BSTP_ASSERT_IMP(a_err_alone, out_v_q && kind_q == KIND_ERROR, last_q && !eoi_q,
		"error word must be the only word of its byte")
	`BSTP_ASSERT_IMP(a_eoi_last, out_v_q && eoi_q, last_q,
		"end of image on a word that is not last of its byte")
	`BSTP_ASSERT_IMP(a_mid_job, idx_q != 3'd0, head_valid,
		"job left the queue before all its words went out")

endmodule

[hw/rtl/bmp_stream_to_tricolor_pixels.sv]
// Channel  | Dir | Word        | Fields
// byte_in  | in  | byte_word_t | data_byte, start_of_file
// pix_out  | out | pix_word_t  | kind, pixel_x, pixel_y, color, end_of_image, last_in_run
// cfg      | in  | write only  | cfg_we, cfg_idx, cfg_wdata
//
// A byte is taken every cycle while the two-entry job queue has room; a byte that
// yields n results holds the back end until all n are out, one result word per
// cycle from its output register while the sink is ready. Results are loaded
// into that register once their job reaches the queue head.
// Reset puts the thresholds to 200, 100 and 12 and waits for header byte zero.
// A stalled output backs up the queue, then the input; either side may stall freely.
module bmp_stream_to_tricolor_pixels #(
	parameter int COORD_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bstp_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [7:0]                        cfg_wdata,
	bstp_stream_if.sink                       byte_in,
	bstp_stream_if.source                     pix_out
);
	import bstp_pkg::*;

	logic q_full, push, pop, head_valid;
	job_t push_job, head;

	bstp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.byte_in   (byte_in),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	bstp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	bstp_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.pix_out    (pix_out)
	);

endmodule
